>>> sv/wzh_pkg.sv
package wzh_pkg;

	localparam int IDX_W   = 4;
	localparam int COORD_W = 16;
	localparam int SIZE_W  = 15;
	localparam int TB_W    = 8;
	localparam int DEPTH_W = 5;
	localparam logic [TB_W-1:0] TB_RESET = 8'd24;

	typedef enum logic [2:0] {
		REQ_WRITE  = 3'd0,
		REQ_RAISE  = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_TOP    = 3'd3,
		REQ_FRAME  = 3'd4,
		REQ_CLIENT = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_REMOVE,
		ST_PUSH,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                      en;
		logic [IDX_W-1:0]          slot;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SIZE_W-1:0]         w;
		logic [SIZE_W-1:0]         h;
		logic                      active;
		logic                      minimized;
	} geom_wr_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] slot;
	} geom_rd_t;

	typedef struct packed {
		logic             valid;
		logic             hit;
		logic [IDX_W-1:0] slot;
	} geom_res_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SIZE_W-1:0]         w;
		logic [SIZE_W-1:0]         h;
	} geom_t;

endpackage

>>> sv/window_zorder_hit_test.sv
// Write and unknown requests go from start straight to finish; remove walks the whole order,
// raise removes and then pushes on top, top query and hit tests scan down from the top entry.
// One item at a time: s_tready returns in the cycle after the result is loaded, and a result
// is loaded only once the previous one has been taken on m_tready.
// In a scan, each cycle one stack entry is read, fetched and compared through the shared compare unit.
// Reset: order empty, all windows inactive, title bar height 24.
module window_zorder_hit_test import wzh_pkg::*; #(
	parameter int WINDOW_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// win_index, pos_x, pos_y, size_w, size_h, is_active, is_minimized
	input  logic [71:0]         s_tdata,
	// req_type
	input  logic [2:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// found, hit_index, stack_depth
	output logic [15:0]         m_tdata,
	input  logic                cfg_we,
	input  logic [TB_W-1:0]     cfg_wdata
);

	localparam int AW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int CW = $clog2(WINDOW_SLOTS + 1);

	state_t state_q, state_d;

	req_t                      req_q;
	logic [IDX_W-1:0]          slot_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic [SIZE_W-1:0]         w_q, h_q;
	logic                      act_q, min_q;
	logic [TB_W-1:0]           tb_q;

	logic [CW-1:0]    count_q, ptr_q, ptr_dec;
	logic             fnd_q, hit_found_q;
	logic [IDX_W-1:0] hit_slot_q;
	logic             rd_v_s1;
	logic [AW-1:0]    rd_idx_s1, rd_idx_dec;
	logic [IDX_W-1:0] stack_rd_s1;
	logic             out_valid_q;
	logic [15:0]      out_data_q;

	logic [IDX_W-1:0] stack_mem [WINDOW_SLOTS];

	logic             slot_ok, issue, mem_we, room, out_load, rm_done;
	logic [AW-1:0]    rd_addr, mem_waddr;
	logic [IDX_W-1:0] mem_wdata;
	geom_wr_t         gwr;
	geom_rd_t         grd;
	geom_res_t        gres;

	assign slot_ok    = 32'(slot_q) < WINDOW_SLOTS;
	assign ptr_dec    = ptr_q - 1'b1;
	assign rd_idx_dec = rd_idx_s1 - 1'b1;
	assign room       = count_q < CW'(WINDOW_SLOTS);
	assign out_load   = (state_q == ST_FIN) && (!out_valid_q || m_tready);
	assign rm_done    = (ptr_q == count_q) && !rd_v_s1;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_START;
			end
			ST_START: begin
				case (req_q)
					REQ_RAISE, REQ_REMOVE: state_d = slot_ok ? ST_REMOVE : ST_FIN;
					REQ_TOP, REQ_FRAME, REQ_CLIENT: state_d = ST_SCAN;
					default: state_d = ST_FIN;
				endcase
			end
			ST_REMOVE: begin
				if (rm_done) state_d = (req_q == REQ_RAISE) ? ST_PUSH : ST_FIN;
			end
			ST_PUSH: state_d = ST_FIN;
			ST_SCAN: begin
				if (gres.valid && gres.hit) begin
					state_d = ST_FIN;
				end else if (ptr_q == '0 && !rd_v_s1 && !gres.valid) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		issue     = ((state_q == ST_REMOVE) && (ptr_q < count_q)) ||
		            ((state_q == ST_SCAN) && (ptr_q != '0));
		rd_addr   = (state_q == ST_SCAN) ? ptr_dec[AW-1:0] : ptr_q[AW-1:0];
		mem_we    = ((state_q == ST_REMOVE) && rd_v_s1 && fnd_q) ||
		            ((state_q == ST_PUSH) && room);
		mem_waddr = (state_q == ST_PUSH) ? count_q[AW-1:0] : rd_idx_dec;
		mem_wdata = (state_q == ST_PUSH) ? slot_q : stack_rd_s1;

		gwr.en        = (state_q == ST_START) && (req_q == REQ_WRITE) && slot_ok;
		gwr.slot      = slot_q;
		gwr.x         = px_q;
		gwr.y         = py_q;
		gwr.w         = w_q;
		gwr.h         = h_q;
		gwr.active    = act_q;
		gwr.minimized = min_q;

		grd.valid = rd_v_s1 && (state_q == ST_SCAN);
		grd.slot  = stack_rd_s1;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		stack_rd_s1 <= stack_mem[rd_addr];
		rd_idx_s1   <= rd_addr;
		if (s_tvalid && s_tready) begin
			req_q  <= req_t'(s_tuser);
			slot_q <= s_tdata[3:0];
			px_q   <= s_tdata[19:4];
			py_q   <= s_tdata[35:20];
			w_q    <= s_tdata[50:36];
			h_q    <= s_tdata[65:51];
			act_q  <= s_tdata[66];
			min_q  <= s_tdata[67];
		end
		if (out_load) begin
			out_data_q <= {6'd0, DEPTH_W'(count_q), hit_slot_q, hit_found_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tb_q        <= TB_RESET;
			count_q     <= '0;
			ptr_q       <= '0;
			fnd_q       <= 1'b0;
			hit_found_q <= 1'b0;
			hit_slot_q  <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (cfg_we) tb_q <= cfg_wdata;
			case (state_q)
				ST_START: begin
					fnd_q       <= 1'b0;
					hit_found_q <= 1'b0;
					hit_slot_q  <= '0;
					ptr_q       <= (req_q == REQ_RAISE || req_q == REQ_REMOVE) ? '0 : count_q;
				end
				ST_REMOVE: begin
					if (issue) ptr_q <= ptr_q + 1'b1;
					if (rd_v_s1 && !fnd_q && stack_rd_s1 == slot_q) fnd_q <= 1'b1;
					if (rm_done && fnd_q) count_q <= count_q - 1'b1;
				end
				ST_PUSH: begin
					if (room) count_q <= count_q + 1'b1;
				end
				ST_SCAN: begin
					if (issue) ptr_q <= ptr_dec;
					if (gres.valid && gres.hit) begin
						hit_found_q <= 1'b1;
						hit_slot_q  <= gres.slot;
					end
				end
				default: ;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	wzh_geom #(
		.WINDOW_SLOTS(WINDOW_SLOTS)
	) u_geom (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (gwr),
		.rd    (grd),
		.mode  (req_q),
		.px    (px_q),
		.py    (py_q),
		.tb    (tb_q),
		.res   (gres)
	);

endmodule

>>> sv/wzh_geom.sv
module wzh_geom import wzh_pkg::*; #(
	parameter int WINDOW_SLOTS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  geom_wr_t                  wr,
	input  geom_rd_t                  rd,
	input  req_t                      mode,
	input  logic signed [COORD_W-1:0] px,
	input  logic signed [COORD_W-1:0] py,
	input  logic [TB_W-1:0]           tb,
	output geom_res_t                 res
);

	localparam int AW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

	geom_t            geom_mem [WINDOW_SLOTS];
	logic [1:0]       marks_q  [WINDOW_SLOTS];

	geom_t            g_s2;
	logic [1:0]       marks_s2;
	logic             valid_s2;
	logic [IDX_W-1:0] slot_s2;

	logic signed [17:0] x0, x1, ylo, y1, pxe, pye, yt;
	logic               in_box;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			geom_mem[AW'(wr.slot)] <= '{x: wr.x, y: wr.y, w: wr.w, h: wr.h};
		end
		g_s2    <= geom_mem[AW'(rd.slot)];
		slot_s2 <= rd.slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_SLOTS; i++) begin
				marks_q[i] <= 2'b00;
			end
			marks_s2 <= 2'b00;
			valid_s2 <= 1'b0;
		end else begin
			if (wr.en) begin
				marks_q[AW'(wr.slot)] <= {wr.minimized, wr.active};
			end
			marks_s2 <= marks_q[AW'(rd.slot)];
			valid_s2 <= rd.valid;
		end
	end

	// shared compare unit, one stack entry per cycle
	always_comb begin
		x0     = {{2{g_s2.x[COORD_W-1]}}, g_s2.x};
		x1     = x0 + $signed({3'b000, g_s2.w});
		yt     = {{2{g_s2.y[COORD_W-1]}}, g_s2.y};
		y1     = yt + $signed({10'd0, tb}) + $signed({3'b000, g_s2.h});
		ylo    = (mode == REQ_FRAME) ? yt : (yt + $signed({10'd0, tb}));
		pxe    = {{2{px[COORD_W-1]}}, px};
		pye    = {{2{py[COORD_W-1]}}, py};
		in_box = (pxe >= x0) && (pxe < x1) && (pye >= ylo) && (pye < y1);
		res.valid = valid_s2;
		res.slot  = slot_s2;
		res.hit   = (marks_s2 == 2'b01) && ((mode == REQ_TOP) || in_box);
	end

endmodule

>>> tb/window_zorder_hit_test_tb.sv
module window_zorder_hit_test_tb;
	import wzh_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [2:0]         kind;
		logic [3:0]         slot;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
		logic               act;
		logic               mini;
	} request_t;

	typedef struct {
		logic       found;
		logic [3:0] slot;
		logic [4:0] depth;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	// shadow of the window manager
	logic [3:0]         zorder [SLOTS];
	int                 zdepth = 0;
	logic signed [15:0] win_x [SLOTS];
	logic signed [15:0] win_y [SLOTS];
	logic [14:0]        win_w [SLOTS];
	logic [14:0]        win_h [SLOTS];
	logic               win_act [SLOTS];
	logic               win_min [SLOTS];
	int                 title_h = TB_RESET;

	request_t pending_reqs [$];
	answer_t  due_answers [$];
	request_t offered;
	int       errors = 0;
	int       tx_gap_left = 0;
	int       rx_stall_left = 0;
	bit       tx_gaps = 1'b0;
	bit       rx_gaps = 1'b0;
	logic     hold_go = 1'b0;
	int       hold_left = 0;

	window_zorder_hit_test u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			zorder[i] = '0;
			win_x[i] = '0;
			win_y[i] = '0;
			win_w[i] = '0;
			win_h[i] = '0;
			win_act[i] = 1'b0;
			win_min[i] = 1'b0;
		end
	end

	task automatic zorder_drop(input logic [3:0] s);
		int j;
		bit gone;
		gone = 1'b0;
		for (j = 0; j < zdepth; j++) begin
			if (!gone && zorder[j] == s)
				gone = 1'b1;
			if (gone && j + 1 < zdepth)
				zorder[j] = zorder[j + 1];
		end
		if (gone)
			zdepth--;
	endtask

	task automatic zorder_apply(input request_t r, output answer_t a);
		int  i, px, py, x0, x1, y0, y1;
		int  s;
		bit  got;
		got = 1'b0;
		a.found = 1'b0;
		a.slot = '0;
		px = r.x;
		py = r.y;
		case (r.kind)
			REQ_WRITE: begin
				win_x[r.slot] = r.x;
				win_y[r.slot] = r.y;
				win_w[r.slot] = r.w;
				win_h[r.slot] = r.h;
				win_act[r.slot] = r.act;
				win_min[r.slot] = r.mini;
			end
			REQ_RAISE: begin
				zorder_drop(r.slot);
				if (zdepth < SLOTS) begin
					zorder[zdepth] = r.slot;
					zdepth++;
				end
			end
			REQ_REMOVE: zorder_drop(r.slot);
			REQ_TOP, REQ_FRAME, REQ_CLIENT: begin
				for (i = zdepth - 1; i >= 0; i--) begin
					s = zorder[i];
					if (!got && win_act[s] && !win_min[s]) begin
						x0 = win_x[s];
						x1 = x0 + int'(win_w[s]);
						if (r.kind == REQ_FRAME) begin
							y0 = win_y[s];
							y1 = y0 + int'(win_h[s]) + title_h;
						end else begin
							y0 = int'(win_y[s]) + title_h;
							y1 = y0 + int'(win_h[s]);
						end
						if (r.kind == REQ_TOP ||
								(px >= x0 && px < x1 && py >= y0 && py < y1)) begin
							got = 1'b1;
							a.found = 1'b1;
							a.slot = s[3:0];
						end
					end
				end
			end
			default: ;
		endcase
		a.depth = zdepth[4:0];
	endtask

	// sender
	always @(posedge clk) begin
		answer_t a;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				zorder_apply(offered, a);
				due_answers.push_back(a);
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap_left != 0) begin
					tx_gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					offered = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= offered.kind;
					s_tdata <= {4'b0, offered.mini, offered.act, offered.h, offered.w,
						offered.y, offered.x, offered.slot};
					tx_gap_left = tx_gaps ? $urandom_range(0, 14) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				rx_stall_left = rx_gaps ? $urandom_range(0, 14) : 0;
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (rx_stall_left != 0) begin
				rx_stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result check
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_answers.size() == 0) begin
				errors++;
				$display("%t unexpected item: expected none, actual %h", $realtime, m_tdata);
			end else begin
				a = due_answers.pop_front();
				if (m_tdata[0] !== a.found) begin
					errors++;
					$display("%t found: expected %b, actual %b", $realtime, a.found, m_tdata[0]);
				end
				if (m_tdata[4:1] !== a.slot) begin
					errors++;
					$display("%t hit_index: expected %0d, actual %0d", $realtime, a.slot,
						m_tdata[4:1]);
				end
				if (m_tdata[9:5] !== a.depth) begin
					errors++;
					$display("%t stack_depth: expected %0d, actual %0d", $realtime, a.depth,
						m_tdata[9:5]);
				end
			end
		end
	end

	function automatic request_t mk(input logic [2:0] kind, input int slot, input int x,
			input int y, input int w, input int h, input bit act, input bit mini);
		request_t r;
		r.kind = kind;
		r.slot = slot[3:0];
		r.x = x[15:0];
		r.y = y[15:0];
		r.w = w[14:0];
		r.h = h[14:0];
		r.act = act;
		r.mini = mini;
		return r;
	endfunction

	function automatic int rand_coord();
		if ($urandom_range(0, 99) < 80)
			return int'($urandom_range(0, 700)) - 350;
		return $urandom;
	endfunction

	function automatic int rand_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10)
			return 0;
		if (p < 20)
			return $urandom;
		return $urandom_range(1, 400);
	endfunction

	function automatic request_t rand_request();
		request_t r;
		int p;
		r = mk(REQ_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom,
			bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
		p = $urandom_range(0, 99);
		if (p < 16) begin
			r.x = 16'(rand_coord());
			r.y = 16'(rand_coord());
			r.w = 15'(rand_size());
			r.h = 15'(rand_size());
			r.act = $urandom_range(0, 99) < 85;
			r.mini = $urandom_range(0, 99) < 20;
		end else if (p < 38) begin
			r.kind = REQ_RAISE;
		end else if (p < 47) begin
			r.kind = REQ_REMOVE;
		end else if (p < 55) begin
			r.kind = REQ_TOP;
		end else if (p < 96) begin
			r.kind = p < 76 ? REQ_FRAME : REQ_CLIENT;
			r.x = 16'(rand_coord());
			r.y = 16'(rand_coord());
		end else begin
			r.kind = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
		end
		return r;
	endfunction

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++)
			pending_reqs.push_back(rand_request());
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || s_tvalid || due_answers.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic set_title(input logic [7:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		title_h = v;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_reqs.push_back(mk(REQ_TOP, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_WRITE, 0, -32768, -32768, 32767, 32767, 1, 0));
		pending_reqs.push_back(mk(REQ_WRITE, 15, 32767, 32767, 0, 0, 1, 0));
		pending_reqs.push_back(mk(REQ_RAISE, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_RAISE, 15, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_TOP, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_FRAME, 0, -32768, -32768, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_CLIENT, 0, -32768, -32768, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_CLIENT, 0, -32768, -32744, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_FRAME, 0, 32767, 32767, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_FRAME, 0, -2, 32767, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_WRITE, 3, -10, -10, 20, 20, 1, 1));
		pending_reqs.push_back(mk(REQ_RAISE, 3, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_TOP, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_RAISE, 7, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_REMOVE, 7, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_REMOVE, 7, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_RAISE, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_SPARE_LO, 5, 1, 1, 1, 1, 1, 1));
		pending_reqs.push_back(mk(REQ_SPARE_HI, 5, 1, 1, 1, 1, 1, 1));
		pending_reqs.push_back(mk(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_CLIENT, 0, 0, 0, 0, 0, 0, 0));
		for (int s = 0; s < SLOTS; s++)
			pending_reqs.push_back(mk(REQ_RAISE, s, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_RAISE, 3, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_TOP, 0, 0, 0, 0, 0, 0, 0));
		drain();

		set_title(8'd0);
		queue_random(250);
		drain();

		set_title(8'd255);
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		queue_random(250);
		repeat (40) @(posedge clk);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		drain();

		set_title(8'($urandom_range(1, 254)));
		queue_random(300);
		drain();

		set_title(8'd24);
		rx_gaps = 1'b0;
		queue_random(150);
		drain();

		set_title(8'd1);
		tx_gaps = 1'b0;
		rx_gaps = 1'b1;
		queue_random(150);
		drain();

		if (errors == 0 && due_answers.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
